// File: hdl/utf8d_pkg.sv
// utf8d_pkg: types and constants of the UTF-8 decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package utf8d_pkg;

  localparam int CP_W = 21;

  localparam logic [7:0] ASCII_MAX = 8'h7f;
  localparam logic [7:0] CONT_MAX  = 8'hbf;
  localparam logic [7:0] LEAD2_MAX = 8'hdf;
  localparam logic [7:0] LEAD3_MAX = 8'hef;
  localparam logic [7:0] LEAD4_MAX = 8'hf7;

  localparam logic [1:0] PEND_NONE = 2'd0;
  localparam logic [1:0] PEND_ONE  = 2'd1;
  localparam logic [1:0] PEND_TWO  = 2'd2;
  localparam logic [1:0] PEND_3    = 2'd3;

  localparam logic [CP_W-1:0] REPL_RESET = 21'd111;

  // One queued job: one or two result words.
  typedef struct packed {
    logic            two;   // replacement word goes ahead of the final word
    logic [CP_W-1:0] cp;
    logic            rep;   // final word is the replacement
    logic            last;  // final word closes the string
  } entry_t;

endpackage

`default_nettype wire

// File: hdl/utf8d_front.sv
// utf8d_front: byte classifier, pending count and accumulator.
// Depends on utf8d_pkg; feeds jobs to utf8d_fifo.
`default_nettype none

module utf8d_front (
  input  wire                clk,
  input  wire                rst,
  input  wire                accept,
  input  wire  [7:0]         byte_in,
  input  wire                string_last,
  output logic               job_push,
  output utf8d_pkg::entry_t  job
);
  import utf8d_pkg::*;

  logic [1:0]      pending_count, pending_count_next;
  logic [CP_W-1:0] accumulator, accumulator_next;
  logic [1:0]      cnt_tmp;
  logic            emit;

  always_comb begin
    cnt_tmp          = pending_count;
    accumulator_next = accumulator;
    emit             = 1'b0;
    job.two          = 1'b0;
    job.cp           = {{(CP_W-8){1'b0}}, byte_in};
    job.rep          = 1'b0;
    job.last         = string_last;
    if (byte_in <= ASCII_MAX) begin
      emit    = 1'b1;
      job.two = (pending_count != PEND_NONE);
      cnt_tmp = PEND_NONE;
    end else if (byte_in <= CONT_MAX) begin
      if (pending_count != PEND_NONE) begin
        accumulator_next = {accumulator[CP_W-7:0], byte_in[5:0]};
        cnt_tmp          = pending_count - 2'd1;
        if (cnt_tmp == PEND_NONE) begin
          emit   = 1'b1;
          job.cp = accumulator_next;
        end
      end else begin
        emit    = 1'b1;
        job.rep = 1'b1;
      end
    end else if (byte_in <= LEAD2_MAX) begin
      cnt_tmp          = PEND_ONE;
      accumulator_next = {{(CP_W-5){1'b0}}, byte_in[4:0]};
    end else if (byte_in <= LEAD3_MAX) begin
      cnt_tmp          = PEND_TWO;
      accumulator_next = {{(CP_W-4){1'b0}}, byte_in[3:0]};
    end else if (byte_in <= LEAD4_MAX) begin
      cnt_tmp          = PEND_3;
      accumulator_next = {{(CP_W-3){1'b0}}, byte_in[2:0]};
    end else begin
      emit    = 1'b1;
      job.rep = 1'b1;
      cnt_tmp = PEND_NONE;
    end
    // flush of an unfinished sequence at end of string
    if (string_last && cnt_tmp != PEND_NONE) begin
      emit    = 1'b1;
      job.rep = 1'b1;
    end
    pending_count_next = string_last ? PEND_NONE : cnt_tmp;
    job_push           = accept && emit;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pending_count <= PEND_NONE;
      accumulator   <= '0;
    end else if (accept) begin
      pending_count <= pending_count_next;
      accumulator   <= accumulator_next;
    end
  end

`ifndef SYNTHESIS
  a_last_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && string_last) |=> (pending_count == PEND_NONE))
    else $error("pending count left over after end of string");
`endif

endmodule

`default_nettype wire

// File: hdl/utf8d_fifo.sv
// utf8d_fifo: short job queue between front and back.
// Depends on utf8d_pkg for the job type.
`default_nettype none

module utf8d_fifo #(
  parameter int DEPTH = 4
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                push,
  input  utf8d_pkg::entry_t  wr_data,
  input  wire                pop,
  output utf8d_pkg::entry_t  head,
  output logic               full,
  output logic               empty
);
  import utf8d_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wr_ptr, rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");
  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (do_push && !do_pop) |=> !empty)
    else $error("queue empty after a word was written");
`endif

endmodule

`default_nettype wire

// File: hdl/utf8d_back.sv
// utf8d_back: expands queued jobs into one or two result words.
// Depends on utf8d_pkg; reads the head of utf8d_fifo.
`default_nettype none

module utf8d_back (
  input  wire                       clk,
  input  wire                       rst,
  input  utf8d_pkg::entry_t         head,
  input  wire                       q_empty,
  input  wire  [utf8d_pkg::CP_W-1:0] replacement_code,
  input  wire                       pop,
  output logic                      q_pop,
  output logic [utf8d_pkg::CP_W-1:0] code_point,
  output logic                      replaced,
  output logic                      run_last,
  output logic                      string_end
);
  import utf8d_pkg::*;

  logic phase;
  logic first;

  assign first      = head.two && !phase;
  assign code_point = (first || head.rep) ? replacement_code : head.cp;
  assign replaced   = first || head.rep;
  assign run_last   = !first;
  assign string_end = !first && head.last;
  assign q_pop      = pop && !q_empty && !first;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
    end else if (pop && !q_empty) begin
      phase <= first;
    end
  end

`ifndef SYNTHESIS
  a_phase_head: assert property (@(posedge clk) disable iff (rst)
    phase |-> (!q_empty && head.two))
    else $error("second word phase without a two-word job");
`endif

endmodule

`default_nettype wire

// File: hdl/utf8_to_code_point_decoder.sv
// utf8_to_code_point_decoder: top level of the UTF-8 decoder.
// Depends on utf8d_pkg, utf8d_front, utf8d_fifo, utf8d_back.
//
//   channel  handshake              payload
//   input    push / full            byte_in, string_last
//   result   empty / pop            code_point, replaced, run_last, string_end
//   config   cfg_valid / cfg_ready  cfg_data (replacement_code)
//
// One byte is taken per cycle while the job queue has room; the front updates
// its pending count and accumulator in that same cycle. The back delivers one
// word per cycle while pop is high and the queue is not empty. Bytes that
// yield no word never enter the queue. Reset (rst, synchronous)
// empties the queue and clears the decode state; cfg_ready is always high.
`default_nettype none

module utf8_to_code_point_decoder #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        push,
  output logic                       full,
  input  wire  [7:0]                 byte_in,
  input  wire                        string_last,
  output logic                       empty,
  input  wire                        pop,
  output logic [utf8d_pkg::CP_W-1:0] code_point,
  output logic                       replaced,
  output logic                       run_last,
  output logic                       string_end,
  input  wire                        cfg_valid,
  output logic                       cfg_ready,
  input  wire  [utf8d_pkg::CP_W-1:0] cfg_data
);
  import utf8d_pkg::*;

  logic [CP_W-1:0] replacement_code;
  logic            accept;
  logic            job_push;
  entry_t          job;
  entry_t          head;
  logic            q_pop;

  assign cfg_ready = 1'b1;
  assign accept    = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      replacement_code <= REPL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      replacement_code <= cfg_data;
    end
  end

  utf8d_front u_front (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .byte_in     (byte_in),
    .string_last (string_last),
    .job_push    (job_push),
    .job         (job)
  );

  utf8d_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (job_push),
    .wr_data (job),
    .pop     (q_pop),
    .head    (head),
    .full    (full),
    .empty   (empty)
  );

  utf8d_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head             (head),
    .q_empty          (empty),
    .replacement_code (replacement_code),
    .pop              (pop),
    .q_pop            (q_pop),
    .code_point       (code_point),
    .replaced         (replaced),
    .run_last         (run_last),
    .string_end       (string_end)
  );

endmodule

`default_nettype wire

// File: sim/tb_utf8_to_code_point_decoder.sv
// tb_utf8_to_code_point_decoder: self-checking bench for the UTF-8 decoder.
// Drives byte strings through the push/full side, predicts every code point word
// and checks the pop/empty side. Depends on utf8d_pkg and utf8_to_code_point_decoder.
`timescale 1ns / 100ps

module tb_utf8_to_code_point_decoder;
  import utf8d_pkg::*;

  typedef struct packed {
    logic [CP_W-1:0] cp;
    logic            rep;
    logic            run_last;
    logic            str_end;
  } cp_word_t;

  class utf8_scoreboard;
    logic [CP_W-1:0] repl_code;
    logic [1:0]      pend;
    logic [CP_W-1:0] acc;
    cp_word_t        words_due[$];
    int              mismatches;
    int              bytes_seen;
    int              words_seen;
    int              repl_seen;
    int              double_bytes;

    function new();
      repl_code = REPL_RESET;
      pend = PEND_NONE;
      acc = '0;
    endfunction

    function void set_replacement(logic [CP_W-1:0] v);
      repl_code = v;
    endfunction

    function cp_word_t word_of(logic [CP_W-1:0] cp, logic rep);
      cp_word_t w;
      w.cp = cp;
      w.rep = rep;
      w.run_last = 1'b0;
      w.str_end = 1'b0;
      return w;
    endfunction

    function void note_byte(logic [7:0] b, logic last);
      cp_word_t w[$];
      bytes_seen++;
      if (b <= ASCII_MAX) begin
        if (pend != PEND_NONE) begin
          w.push_back(word_of(repl_code, 1'b1));
          pend = PEND_NONE;
        end
        w.push_back(word_of({13'd0, b}, 1'b0));
      end else if (b <= CONT_MAX) begin
        if (pend != PEND_NONE) begin
          acc = {acc[CP_W-7:0], b[5:0]};
          pend = pend - 2'd1;
          if (pend == PEND_NONE) w.push_back(word_of(acc, 1'b0));
        end else begin
          w.push_back(word_of(repl_code, 1'b1));
        end
      end else if (b <= LEAD2_MAX) begin
        pend = PEND_ONE;
        acc = {16'd0, b[4:0]};
      end else if (b <= LEAD3_MAX) begin
        pend = PEND_TWO;
        acc = {17'd0, b[3:0]};
      end else if (b <= LEAD4_MAX) begin
        pend = PEND_3;
        acc = {18'd0, b[2:0]};
      end else begin
        w.push_back(word_of(repl_code, 1'b1));
        pend = PEND_NONE;
      end
      // end of string flushes a dangling sequence
      if (last && pend != PEND_NONE && w.size() < 2) w.push_back(word_of(repl_code, 1'b1));
      if (last) pend = PEND_NONE;
      if (w.size() > 0) begin
        w[w.size()-1].run_last = 1'b1;
        w[w.size()-1].str_end = last;
      end
      if (w.size() == 2) double_bytes++;
      foreach (w[i]) words_due.push_back(w[i]);
    endfunction

    function void check_word(logic [CP_W-1:0] cp, logic rep, logic rl, logic se);
      cp_word_t exp_w;
      words_seen++;
      if (rep) repl_seen++;
      if (words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: unexpected word cp=%h rep=%b run_last=%b string_end=%b",
                   $time, cp, rep, rl, se);
        return;
      end
      exp_w = words_due.pop_front();
      if (cp !== exp_w.cp || rep !== exp_w.rep || rl !== exp_w.run_last ||
          se !== exp_w.str_end) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: word mismatch exp cp=%h rep=%b rl=%b se=%b got cp=%h rep=%b rl=%b se=%b",
                   $time, exp_w.cp, exp_w.rep, exp_w.run_last, exp_w.str_end,
                   cp, rep, rl, se);
      end
    endfunction
  endclass

  logic            clk = 1'b0;
  logic            rst = 1'b1;
  logic            push = 1'b0;
  logic [7:0]      byte_in = 8'h00;
  logic            string_last = 1'b0;
  logic            pop = 1'b0;
  logic            cfg_valid = 1'b0;
  logic [CP_W-1:0] cfg_data = '0;
  logic            full;
  logic            empty;
  logic [CP_W-1:0] code_point;
  logic            replaced;
  logic            run_last;
  logic            string_end;
  logic            cfg_ready;

  utf8_scoreboard  sb;
  int              send_idle = 0;
  int              recv_idle = 0;
  logic            hold_ask = 1'b0;
  logic [7:0]      text_q[$];
  int              settings_used = 1;

  localparam int HOLD_CYCLES = 150;
  localparam int SETTLE = 8;

  utf8_to_code_point_decoder dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .byte_in     (byte_in),
    .string_last (string_last),
    .empty       (empty),
    .pop         (pop),
    .code_point  (code_point),
    .replaced    (replaced),
    .run_last    (run_last),
    .string_end  (string_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst) begin
      if (pop && !empty) sb.check_word(code_point, replaced, run_last, string_end);
      if (push && !full) sb.note_byte(byte_in, string_last);
    end
  end

  // result side: random pop, plus one long hold-off on request
  initial begin : receiver
    bit held;
    held = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ask && !held) begin
        pop <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        held = 1'b1;
      end
      pop <= !rst && ($urandom_range(99) >= recv_idle);
    end
  end

  initial begin : watchdog
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    byte_in <= b;
    string_last <= last;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  task automatic send_text();
    foreach (text_q[i]) send_byte(text_q[i], i == text_q.size() - 1);
    text_q.delete();
  endtask

  function automatic logic [7:0] cont_byte();
    return 8'h80 | 8'($urandom_range(63));
  endfunction

  // one unit of text: mostly well-formed, some truncated or raw bytes
  function automatic void add_unit();
    int r;
    int len;
    int n;
    r = $urandom_range(99);
    len = 0;
    n = 0;
    if (r < 30) begin
      text_q.push_back(8'($urandom_range(8'h7f)));
    end else if (r < 82) begin
      if (r < 50) begin
        text_q.push_back(8'($urandom_range(8'hdf, 8'hc0)));
        n = 1;
      end else if (r < 68) begin
        text_q.push_back(8'($urandom_range(8'hef, 8'he0)));
        n = 2;
      end else begin
        text_q.push_back(8'($urandom_range(8'hf7, 8'hf0)));
        n = 3;
      end
      repeat (n) text_q.push_back(cont_byte());
    end else if (r < 90) begin
      len = $urandom_range(4, 2);
      text_q.push_back(len == 2 ? 8'($urandom_range(8'hdf, 8'hc0)) :
                       len == 3 ? 8'($urandom_range(8'hef, 8'he0)) :
                                  8'($urandom_range(8'hf7, 8'hf0)));
      repeat ($urandom_range(len - 2)) text_q.push_back(cont_byte());
    end else begin
      text_q.push_back(8'($urandom_range(255)));
    end
  endfunction

  task automatic random_strings(input int n_bytes);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      repeat ($urandom_range(8, 1)) add_unit();
      sent += text_q.size();
      send_text();
    end
  endtask

  task automatic drain(input int settle);
    int waited;
    push <= 1'b0;
    waited = 0;
    while (sb.words_due.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (settle) @(posedge clk);
  endtask

  task automatic write_replacement(input logic [CP_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_replacement(v);
    settings_used++;
  endtask

  initial begin : stimulus
    sb = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: extremes, every sequence length, each malformed case
    text_q = '{8'h00, 8'h7f};
    send_text();
    text_q = '{8'hc2, 8'ha9, 8'hef, 8'h82, 8'hac, 8'hf7, 8'hbf, 8'hbf, 8'hbf};
    send_text();
    text_q = '{8'h80, 8'hf8, 8'hff, 8'hc3, 8'h41, 8'he0, 8'hc0, 8'h80, 8'hdf};
    send_text();
    text_q = '{8'hf0, 8'h90, 8'hff};
    send_text();
    text_q = '{8'he1, 8'hbf};
    send_text();

    drain(SETTLE);
    write_replacement(21'h000000);
    send_idle = 38;
    recv_idle = 59;
    random_strings(220);

    drain(SETTLE);
    write_replacement(21'h1fffff);
    send_idle = 59;
    recv_idle = 38;
    hold_ask <= 1'b1;
    random_strings(220);

    drain(SETTLE);
    write_replacement(21'($urandom_range(21'h1fffff)));
    send_idle = 0;
    recv_idle = 0;
    random_strings(210);

    drain(SETTLE);
    if (sb.words_due.size() != 0) begin
      $display("%0d expected words never delivered", sb.words_due.size());
      sb.mismatches++;
    end
    $display("Ran %0d bytes into %0d words (%0d replacements, %0d two-word bytes)",
             sb.bytes_seen, sb.words_seen, sb.repl_seen, sb.double_bytes);
    $display("under %0d replacement settings, with idling on both sides and a long output hold",
             settings_used);
    if (sb.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
